[sv/per_user_token_bucket_limiter_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the per-user token bucket limiter
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PER_USER_TOKEN_BUCKET_LIMITER_TOP_MACROS_SVH
`define PER_USER_TOKEN_BUCKET_LIMITER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PTBL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PTBL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/ptbl_pkg.sv]
// ----------------------------------------------------------------------------
// ptbl_pkg
// Types and constants shared by the token bucket limiter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ptbl_pkg;

  localparam int USERS_DEF = 256;
  localparam int UID_W     = 8;
  localparam int TIME_W    = 48;
  localparam int TOK_W     = 16;
  localparam int CFG_IDX_W = 8;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE     = 8'd1;

  localparam logic [TOK_W-1:0] CAPACITY_RST = 16'd10;
  localparam logic [TOK_W-1:0] RATE_RST     = 16'd10;

  // Elapsed time above 2^EL_W ms with a nonzero rate always fills the bucket.
  localparam int EL_W   = 26;
  localparam int PROD_W = EL_W + TOK_W;
  // elapsed * rate at or above 1000 * 2^16 adds at least 2^16 tokens.
  localparam logic [PROD_W-1:0] SAT_PROD = 42'd65536000;
  // floor(p / 1000) = (p * RECIP_M) >> RECIP_SH, exact for p < SAT_PROD
  localparam int RECIP_W  = 27;
  localparam int RECIP_SH = 36;
  localparam logic [RECIP_W-1:0] RECIP_M = 27'd68719477;

  typedef struct packed {
    logic [UID_W-1:0]  user_id;
    logic [TIME_W-1:0] now_ms;
  } req_t;

  typedef struct packed {
    logic             granted;
    logic [TOK_W-1:0] tokens_left;
  } rsp_t;

  typedef struct packed {
    logic [TIME_W-1:0] stamp;
    logic [TOK_W-1:0]  count;
  } bucket_t;

  localparam int BUCKET_W = TIME_W + TOK_W;

endpackage

`default_nettype wire

[sv/ptbl_mem.sv]
// ----------------------------------------------------------------------------
// ptbl_mem
// Bucket table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ptbl_mem #(
  parameter int DEPTH  = 256,
  parameter int WIDTH  = 64,
  parameter int ADDR_W = 8
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output      logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[sv/per_user_token_bucket_limiter_top.sv]
// ----------------------------------------------------------------------------
// per_user_token_bucket_limiter_top
// Token bucket rate limiter with one bucket per user, kept in a table memory.
//
//   channel | direction | handshake              | payload
//   in_     | input     | in_valid / in_ready    | in_data  (user_id, now_ms)
//   out_    | output    | out_valid / out_ready  | out_data (granted, tokens_left)
//   cfg_    | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One request per cycle unless the output stalls; results pass stages a, b, c.
// Table read, elapsed time, refill product and divide-by-1000 reciprocal
// product are separate stages; same-user requests in flight are forwarded.
// Reset clears the per-entry valid flops at once; no clearing pass is needed.
// The whole pipeline holds while out_valid is high and out_ready is low.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

`include "per_user_token_bucket_limiter_top_macros.svh"

module per_user_token_bucket_limiter_top #(
  parameter int USERS = ptbl_pkg::USERS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire ptbl_pkg::req_t                in_data,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      ptbl_pkg::rsp_t                out_data,
  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic [ptbl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ptbl_pkg::TOK_W-1:0]    cfg_data
);

  // Only user ids below 2^UID_W can be addressed.
  localparam int DEPTH  = (USERS < (1 << ptbl_pkg::UID_W)) ? USERS : (1 << ptbl_pkg::UID_W);
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TIME_W = ptbl_pkg::TIME_W;
  localparam int TOK_W  = ptbl_pkg::TOK_W;
  localparam int EL_W   = ptbl_pkg::EL_W;
  localparam int PROD_W = ptbl_pkg::PROD_W;
  localparam int QP_W   = ptbl_pkg::EL_W + ptbl_pkg::RECIP_W;

  // Configuration
  logic [TOK_W-1:0] capacity_r;
  logic [TOK_W-1:0] rate_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= ptbl_pkg::CAPACITY_RST;
      rate_r     <= ptbl_pkg::RATE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ptbl_pkg::REG_CAPACITY: capacity_r <= cfg_data;
        ptbl_pkg::REG_RATE:     rate_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline control
  logic adv;
  logic in_acc;
  logic out_valid_r;
  ptbl_pkg::rsp_t out_rsp_r;

  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_rsp_r;

  logic             in_inr;
  logic [IDX_W-1:0] in_idx;

  assign in_inr = ({24'd0, in_data.user_id} < 32'(USERS));
  assign in_idx = IDX_W'(in_data.user_id);

  // Write-back port (driven by the last stage)
  logic              wr_en;
  logic [IDX_W-1:0]  wr_idx;
  ptbl_pkg::bucket_t wr_ent;

  // Table memory
  ptbl_pkg::bucket_t rd_ent;

  ptbl_mem #(
    .DEPTH  (DEPTH),
    .WIDTH  (ptbl_pkg::BUCKET_W),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_idx),
    .wdata (wr_ent),
    .re    (in_acc),
    .raddr (in_idx),
    .rdata (rd_ent)
  );

  logic [DEPTH-1:0] valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_idx] <= 1'b1;
    end
  end

  // Stage a: table data arrives
  logic              va_r;
  logic              a_inr_r;
  logic [IDX_W-1:0]  a_idx_r;
  logic [TIME_W-1:0] a_now_r;
  logic              byp_hit_r;
  ptbl_pkg::bucket_t byp_ent_r;

  // Stage b: elapsed time
  logic              vb_r;
  logic              b_inr_r;
  logic [IDX_W-1:0]  b_idx_r;
  logic [TIME_W-1:0] b_now_r;
  logic [EL_W-1:0]   b_el_r;
  logic              b_big_r;
  logic [TOK_W-1:0]  b_cnt_r;

  // Stage c: refill product
  logic              vc_r;
  logic              c_inr_r;
  logic [IDX_W-1:0]  c_idx_r;
  logic [TIME_W-1:0] c_now_r;
  logic [EL_W-1:0]   c_p_r;
  logic              c_sat_r;
  logic [TOK_W-1:0]  c_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (adv) begin
      va_r <= in_acc;
    end
  end

  // Catch the write that lands on the same edge as the table read.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_inr_r   <= in_inr;
      a_idx_r   <= in_idx;
      a_now_r   <= in_data.now_ms;
      byp_hit_r <= wr_en && (wr_idx == in_idx);
      byp_ent_r <= wr_ent;
    end
  end

  logic              hit_b;
  logic              hit_c;
  logic              a_known;
  ptbl_pkg::bucket_t a_ent;
  logic [TIME_W-1:0] a_stamp;
  logic [TOK_W-1:0]  a_cnt;
  logic [TIME_W-1:0] a_el;
  logic [TOK_W-1:0]  b_cnt_nxt;

  always_comb begin
    hit_b   = vb_r && b_inr_r && (b_idx_r == a_idx_r);
    hit_c   = vc_r && c_inr_r && (c_idx_r == a_idx_r);
    a_ent   = byp_hit_r ? byp_ent_r : rd_ent;
    a_known = (a_inr_r && valid_r[a_idx_r]) || hit_b || hit_c || byp_hit_r;
    // Youngest older request wins for the stamp
    if (hit_b) begin
      a_stamp = b_now_r;
    end else if (hit_c) begin
      a_stamp = c_now_r;
    end else begin
      a_stamp = a_ent.stamp;
    end
    // A new bucket starts full; an in-flight count arrives by write-back later.
    a_cnt = a_known ? a_ent.count : capacity_r;
    // Treat backward time as no elapsed time
    if (!a_known || (a_now_r < a_stamp)) begin
      a_el = '0;
    end else begin
      a_el = a_now_r - a_stamp;
    end
    b_cnt_nxt = (wr_en && (wr_idx == a_idx_r)) ? wr_ent.count : a_cnt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (adv) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_inr_r <= a_inr_r;
      b_idx_r <= a_idx_r;
      b_now_r <= a_now_r;
      b_el_r  <= a_el[EL_W-1:0];
      b_big_r <= |a_el[TIME_W-1:EL_W];
      b_cnt_r <= b_cnt_nxt;
    end
  end

  logic [PROD_W-1:0] b_prod;
  logic              c_sat_nxt;
  logic [TOK_W-1:0]  c_cnt_nxt;

  always_comb begin
    b_prod    = PROD_W'(b_el_r) * PROD_W'(rate_r);
    c_sat_nxt = (b_big_r && (rate_r != '0)) || (b_prod >= ptbl_pkg::SAT_PROD);
    c_cnt_nxt = (wr_en && (wr_idx == b_idx_r)) ? wr_ent.count : b_cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (adv) begin
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_inr_r <= b_inr_r;
      c_idx_r <= b_idx_r;
      c_now_r <= b_now_r;
      c_p_r   <= b_prod[EL_W-1:0];
      c_sat_r <= c_sat_nxt;
      c_cnt_r <= c_cnt_nxt;
    end
  end

  // Stage c: divide by 1000, cap, take a token, write back
  logic [QP_W-1:0]  c_qprod;
  logic [TOK_W:0]   c_added;
  logic [TOK_W:0]   c_sum;
  logic [TOK_W-1:0] c_fill;
  logic             c_grant;
  ptbl_pkg::rsp_t   rsp_nxt;

  always_comb begin
    c_qprod = QP_W'(c_p_r) * QP_W'(ptbl_pkg::RECIP_M);
    c_added = c_qprod[ptbl_pkg::RECIP_SH +: (TOK_W + 1)];
    c_sum   = {1'b0, c_cnt_r} + c_added;
    if (c_sat_r || (c_sum > {1'b0, capacity_r})) begin
      c_fill = capacity_r;
    end else begin
      c_fill = c_sum[TOK_W-1:0];
    end
    c_grant = (c_fill != '0);
    if (c_inr_r) begin
      rsp_nxt.granted     = c_grant;
      rsp_nxt.tokens_left = c_fill - TOK_W'(c_grant);
    end else begin
      rsp_nxt.granted     = 1'b0;
      rsp_nxt.tokens_left = '0;
    end
    wr_en        = adv && vc_r && c_inr_r;
    wr_idx       = c_idx_r;
    wr_ent.stamp = c_now_r;
    wr_ent.count = rsp_nxt.tokens_left;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_rsp_r <= rsp_nxt;
    end
  end

  `PTBL_ASSERT_NOW(a_grant_below_cap, adv && vc_r && rsp_nxt.granted,
                   rsp_nxt.tokens_left < capacity_r,
                   "granted beat leaves count at or above capacity")
  `PTBL_ASSERT_NOW(a_deny_empty, adv && vc_r && !rsp_nxt.granted,
                   rsp_nxt.tokens_left == '0, "denied beat with tokens left")
  `PTBL_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, va_r,
                    "accepted beat did not enter the pipeline")
  `PTBL_ASSERT_NEXT(a_wb_marks_valid, wr_en, valid_r[$past(wr_idx)],
                    "written entry not marked valid")

endmodule

`default_nettype wire
